[hw/rtl/next_prime_finder_defines.svh]
// Assertion macros for the next_prime_finder port checker.
// No dependencies; included by the checker file.
`ifndef NEXT_PRIME_FINDER_DEFINES_SVH
`define NEXT_PRIME_FINDER_DEFINES_SVH

// Antecedent and consequent in the same cycle.
`define NPF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("next_prime_finder port check failed");

// Consequent in the cycle after the antecedent.
`define NPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next_prime_finder port check failed");

`endif

[hw/rtl/npf_pkg.sv]
// Shared types for the next_prime_finder block.
// No dependencies.
`default_nettype none

package npf_pkg;

    // Status from the remainder unit back to the sequencer.
    typedef struct packed {
        logic done;      // one-cycle pulse: remainder is ready
        logic rem_zero;  // remainder is zero, valid with done
    } t_div_stat;

endpackage

`default_nettype wire

[hw/rtl/npf_div.sv]
// Shared remainder unit: restoring division, one quotient bit per cycle.
// Depends on npf_pkg (t_div_stat).
`default_nettype none

module npf_div #(
    parameter int DIV_WIDTH = 25
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [DIV_WIDTH-1:0]    i_dividend,
    input  wire logic [DIV_WIDTH-1:0]    i_divisor,
    output npf_pkg::t_div_stat           o_stat
);

    localparam int CW = $clog2(DIV_WIDTH + 1);

    logic                 r_busy;
    logic                 r_done;
    logic [CW-1:0]        r_cnt;
    logic [DIV_WIDTH-1:0] r_rem;
    logic [DIV_WIDTH-1:0] r_quo;

    logic [DIV_WIDTH:0]   trial;
    logic [DIV_WIDTH:0]   divisor_ext;
    logic [DIV_WIDTH-1:0] rem_step;

    // Shift in the next dividend bit; subtract when the divisor fits.
    always_comb begin
        trial       = {r_rem, r_quo[DIV_WIDTH-1]};
        divisor_ext = {1'b0, i_divisor};
        if (trial >= divisor_ext) begin
            rem_step = DIV_WIDTH'(trial - divisor_ext);
        end else begin
            rem_step = trial[DIV_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIV_WIDTH);
                r_rem  <= '0;
                r_quo  <= i_dividend;
            end else if (r_busy) begin
                r_rem <= rem_step;
                r_quo <= {r_quo[DIV_WIDTH-2:0], 1'b0};
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done     = r_done;
    assign o_stat.rem_zero = (r_rem == '0);

endmodule

`default_nettype wire

[hw/rtl/next_prime_finder.sv]
// Values 0, 1 and 2 go from accept straight to the output step. Otherwise the word is
// taken, and each odd divisor tried costs a square-bound compare in S_TEST, then the
// remainder steps in the shared unit and its status in S_DIV, summed over every candidate;
// a closing compare and an output step follow. The time is data dependent. Throughput:
// one word at a time; a new word is taken once the result reaches the output register.
// Sync active-low reset: idle.
`default_nettype none

module next_prime_finder #(
    parameter int VALUE_WIDTH = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // input word
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    // result word
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [VALUE_WIDTH:0]        o_next_prime
);

    // Candidates and divisors live at result width; the running square needs
    // one bit more since it may step just past the candidate.
    localparam int W = VALUE_WIDTH + 1;

    localparam logic [W-1:0] PRIME_TWO   = W'(2);
    localparam logic [W-1:0] PRIME_THREE = W'(3);
    localparam logic [W-1:0] FIRST_DIV   = W'(3);
    localparam logic [W:0]   FIRST_SQ    = (W + 1)'(9);

    typedef enum logic [1:0] {
        S_IDLE,   // wait for an input word
        S_TEST,   // compare divisor squared against the candidate
        S_DIV,    // wait for the remainder unit
        S_DONE    // hand the prime to the output register
    } t_state;

    t_state                r_state;
    logic [W-1:0]          r_cand;       // current odd candidate (or final small prime)
    logic [W-1:0]          r_div;        // current odd divisor
    logic [W:0]            r_sq;         // r_div squared, kept by increments
    logic                  r_out_valid;
    logic [W-1:0]          r_out_prime;

    npf_pkg::t_div_stat    div_stat;
    logic                  div_start;
    logic                  bound_passed;
    logic [W-1:0]          n_start_cand;
    logic [W:0]            n_sq;

    // First odd candidate strictly above the value: v|1 if v is even, v+2 if odd.
    assign n_start_cand = {1'b0, i_value | VALUE_WIDTH'(1)}
                        + (i_value[0] ? PRIME_TWO : W'(0));

    // Divisor squared exceeds the candidate: no factor left to find.
    assign bound_passed = (r_sq > {1'b0, r_cand});

    // (d+2)^2 = d^2 + 4d + 4
    assign n_sq = r_sq + (W + 1)'({r_div, 2'b00}) + (W + 1)'(4);

    assign div_start = (r_state == S_TEST) && !bound_passed;

    npf_div #(
        .DIV_WIDTH (W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_cand),
        .i_divisor  (r_div),
        .o_stat     (div_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // Drop the result word once the consumer takes it.
            if (i_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_div <= FIRST_DIV;
                        r_sq  <= FIRST_SQ;
                        if (i_value[VALUE_WIDTH-1:1] == '0) begin
                            // values 0 and 1
                            r_cand  <= PRIME_TWO;
                            r_state <= S_DONE;
                        end else if (i_value == VALUE_WIDTH'(2)) begin
                            r_cand  <= PRIME_THREE;
                            r_state <= S_DONE;
                        end else begin
                            r_cand  <= n_start_cand;
                            r_state <= S_TEST;
                        end
                    end
                end

                S_TEST: begin
                    // Either the candidate is proven prime, or a division starts.
                    if (bound_passed) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_DIV;
                    end
                end

                S_DIV: begin
                    if (div_stat.done) begin
                        if (div_stat.rem_zero) begin
                            // Composite: advance to the next odd candidate.
                            r_cand <= r_cand + PRIME_TWO;
                            r_div  <= FIRST_DIV;
                            r_sq   <= FIRST_SQ;
                        end else begin
                            // Not a factor: advance to the next odd divisor.
                            r_div <= r_div + PRIME_TWO;
                            r_sq  <= n_sq;
                        end
                        r_state <= S_TEST;
                    end
                end

                S_DONE: begin
                    // Hold until the output register is free or being emptied.
                    if (!r_out_valid || i_ready) begin
                        r_out_valid <= 1'b1;
                        r_out_prime <= r_cand;
                        r_state     <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready      = (r_state == S_IDLE);
    assign o_valid      = r_out_valid;
    assign o_next_prime = r_out_prime;

endmodule

`default_nettype wire

[hw/rtl/npf_checker.sv]
// Port-level checker for next_prime_finder, bound to the top level.
// Depends on next_prime_finder_defines.svh (assertion macros).
`default_nettype none

`include "next_prime_finder_defines.svh"

module npf_checker #(
    parameter int VALUE_WIDTH = 24
) (
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   i_valid,
    input wire logic                   o_ready,
    input wire logic [VALUE_WIDTH-1:0] i_value,
    input wire logic                   o_valid,
    input wire logic                   i_ready,
    input wire logic [VALUE_WIDTH:0]   o_next_prime
);

    localparam logic [VALUE_WIDTH:0] NP_ONE = (VALUE_WIDTH + 1)'(1);
    localparam logic [VALUE_WIDTH:0] NP_TWO = (VALUE_WIDTH + 1)'(2);

    logic out_stall;
    logic in_take;
    logic shape_ok;

    assign out_stall = o_valid && !i_ready;
    assign in_take   = i_valid && o_ready;
    assign shape_ok  = (o_next_prime == NP_TWO) || (o_next_prime[0] && (o_next_prime != NP_ONE));

    // A stalled result word holds its value.
    `NPF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_valid && $stable(o_next_prime))

    // Every result is 2 or an odd number of at least 3.
    `NPF_ASSERT_SAME(a_prime_shape, i_clk, i_rst_n, o_valid, shape_ok)

    // After taking a word the block is not ready in the next cycle.
    `NPF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_take, !o_ready)

    // With the output empty at accept, no result appears in the very next cycle, even for a small value.
    `NPF_ASSERT_NEXT(a_no_instant_result, i_clk, i_rst_n, in_take && !o_valid, !o_valid)

endmodule

bind next_prime_finder npf_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_npf_checker (.*);

`default_nettype wire
